// ===== design/tcw_pkg.sv =====
package tcw_pkg;

    // item field widths
    localparam int CMD_W     = 2;
    localparam int CODE_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int CELL_W    = 16;
    localparam int COLOUT_W  = 7;
    localparam int ROWOUT_W  = 5;
    localparam int CURIDX_W  = 11;
    localparam int COLOR_W   = 4;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // APB
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_PUT     = 2'd0;
    localparam cmd_t CMD_READ    = 2'd1;
    localparam cmd_t CMD_CLEAR   = 2'd2;
    localparam cmd_t CMD_RECOLOR = 2'd3;

    localparam logic [CODE_W-1:0] CHAR_NONE    = 8'h00;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CODE_W-1:0] CHAR_ERASE   = 8'h7F;
    localparam logic [CODE_W-1:0] CHAR_BLANK   = 8'h20;

    localparam logic [COLOR_W-1:0] RESET_FG   = 4'hF;
    localparam logic [COLOR_W-1:0] RESET_BG   = 4'h1;
    localparam logic [CELL_W-1:0]  RESET_CELL = {RESET_BG, RESET_FG, CHAR_BLANK};

    typedef logic [1:0] sweep_mode_t;
    localparam sweep_mode_t SW_INIT    = 2'd0;
    localparam sweep_mode_t SW_CLEAR   = 2'd1;
    localparam sweep_mode_t SW_RECOLOR = 2'd2;
    localparam sweep_mode_t SW_SCROLL  = 2'd3;

    typedef struct packed {
        logic        load_in;
        logic        load_out;
        logic        advance_row;
        logic        home_col;
        logic        put_char;
        logic        erase_char;
        logic        mark_sent;
        logic        read_cell;
        logic        sweep_begin;
        sweep_mode_t sweep_mode;
        logic        sweep_run;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic is_zero;
        logic is_newline;
        logic is_erase;
        logic col_zero;
        logic col_full;
        logic row_last;
        logic cnt_last;
        logic sweep_init;
    } stat_t;

endpackage

// ===== design/text_console_writer_core.sv =====
// Text console writer: a ROWS x COLUMNS screen of 16-bit cells (attribute high byte,
// character low byte) with a cursor, driven by a command stream.
// Input beat: s_tuser = command (put / read cell / clear / recolor), s_tdata = char
// code and cell index. Output beat: cell data plus cursor column, row, linear index
// and the cursor-sent / scrolled flags; exactly one output beat per input beat.
// Colors come from two APB registers (foreground at 0x0, background at 0x4).
// Clear, recolor, and a put or newline that scrolls run a cell sweep through the
// single-port-write screen memory (one cell per cycle, read and write pipelined);
// a put at the wrap column first moves the cursor to the next row, then writes the cell.
// A new beat is not taken while an item is in progress; the next beat is taken in the
// same cycle the previous result is loaded into the output register.
// Reset: cursor goes home, colors to white on blue, then a clearing pass writes every
// cell to blank; s_tready stays low after reset release until that pass is done.
// Stall: a held result keeps its output register; one further item is processed
// and waits in the controller until m_tready frees the register.
module text_console_writer_core
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // APB config
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // command stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]       s_tdata,  // char_code[7:0], cell_index[18:8]
    input  logic [tcw_pkg::S_TUSER_W-1:0]       s_tuser,  // command[1:0]
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cell_data[15:0], cursor_col[22:16], cursor_row[27:23], cursor_index[38:28],
    // cursor_sent[39], scrolled[40]
    output logic [tcw_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int OUT_USED_W = tcw_pkg::CELL_W + tcw_pkg::COLOUT_W + tcw_pkg::ROWOUT_W
                              + tcw_pkg::CURIDX_W + 2;
    localparam int OUT_PAD_W  = tcw_pkg::M_TDATA_W - OUT_USED_W;
    localparam int RD_PAD_W   = tcw_pkg::APB_DATA_W - tcw_pkg::COLOR_W;

    logic [tcw_pkg::COLOR_W-1:0] fg_reg;
    logic [tcw_pkg::COLOR_W-1:0] bg_reg;
    logic                        cfg_write;

    tcw_pkg::ctrl_t ctrl;
    tcw_pkg::stat_t stat;

    logic [tcw_pkg::CELL_W-1:0]   cell_data;
    logic [tcw_pkg::COLOUT_W-1:0] cursor_col;
    logic [tcw_pkg::ROWOUT_W-1:0] cursor_row;
    logic [tcw_pkg::CURIDX_W-1:0] cursor_index;
    logic                         cursor_sent;
    logic                         scrolled;

    // APB: zero-wait, word-addressed, bit 2 picks the register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            tcw_pkg::REG_FG: prdata = {{RD_PAD_W{1'b0}}, fg_reg};
            default:         prdata = {{RD_PAD_W{1'b0}}, bg_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tcw_pkg::RESET_FG;
            bg_reg <= tcw_pkg::RESET_BG;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == tcw_pkg::REG_FG)
            begin
                fg_reg <= pwdata[tcw_pkg::COLOR_W-1:0];
            end
            else
            begin
                bg_reg <= pwdata[tcw_pkg::COLOR_W-1:0];
            end
        end
    end

    tcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .ctrl     (ctrl),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    tcw_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .stat             (stat),
        .command          (s_tuser[tcw_pkg::CMD_W-1:0]),
        .char_code        (s_tdata[tcw_pkg::CODE_W-1:0]),
        .cell_index       (s_tdata[tcw_pkg::CODE_W +: tcw_pkg::INDEX_W]),
        .foreground_color (fg_reg),
        .background_color (bg_reg),
        .cell_data        (cell_data),
        .cursor_col       (cursor_col),
        .cursor_row       (cursor_row),
        .cursor_index     (cursor_index),
        .cursor_sent      (cursor_sent),
        .scrolled         (scrolled)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, scrolled, cursor_sent, cursor_index,
                      cursor_row, cursor_col, cell_data};

endmodule

// ===== design/tcw_ctrl.sv =====
module tcw_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  tcw_pkg::stat_t  stat,
    output tcw_pkg::ctrl_t  ctrl,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        ctrl       = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                ctrl.sweep_run = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
                case (stat.cmd)
                    tcw_pkg::CMD_PUT:
                    begin
                        if (stat.is_zero)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (stat.is_erase)
                        begin
                            ctrl.erase_char = !stat.col_zero;
                        end
                        else if (stat.is_newline)
                        begin
                            ctrl.mark_sent = 1'b1;
                            if (stat.row_last)
                            begin
                                ctrl.home_col    = 1'b1;
                                ctrl.sweep_begin = 1'b1;
                                ctrl.sweep_mode  = tcw_pkg::SW_SCROLL;
                                state_next       = S_SWEEP;
                            end
                            else
                            begin
                                ctrl.advance_row = 1'b1;
                            end
                        end
                        else if (stat.col_full)
                        begin
                            // wrap first, write on the next pass through here
                            if (stat.row_last)
                            begin
                                ctrl.home_col    = 1'b1;
                                ctrl.sweep_begin = 1'b1;
                                ctrl.sweep_mode  = tcw_pkg::SW_SCROLL;
                                state_next       = S_SWEEP;
                            end
                            else
                            begin
                                ctrl.advance_row = 1'b1;
                                state_next       = S_EXEC;
                            end
                        end
                        else
                        begin
                            ctrl.put_char = 1'b1;
                        end
                    end
                    tcw_pkg::CMD_READ:
                    begin
                        ctrl.read_cell = 1'b1;
                    end
                    tcw_pkg::CMD_CLEAR:
                    begin
                        ctrl.sweep_begin = 1'b1;
                        ctrl.sweep_mode  = tcw_pkg::SW_CLEAR;
                        state_next       = S_SWEEP;
                    end
                    default:
                    begin
                        ctrl.sweep_begin = 1'b1;
                        ctrl.sweep_mode  = tcw_pkg::SW_RECOLOR;
                        state_next       = S_SWEEP;
                    end
                endcase
            end
            S_SWEEP:
            begin
                ctrl.sweep_run = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // last pipelined cell write lands this cycle
                if (stat.sweep_init)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.cmd == tcw_pkg::CMD_PUT && !stat.is_newline)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ctrl.load_out = 1'b1;
                    s_tready      = 1'b1;
                    if (s_tvalid)
                    begin
                        ctrl.load_in = 1'b1;
                        state_next   = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/tcw_datapath.sv =====
module tcw_datapath
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tcw_pkg::ctrl_t                     ctrl,
    output tcw_pkg::stat_t                     stat,
    input  logic [tcw_pkg::CMD_W-1:0]          command,
    input  logic [tcw_pkg::CODE_W-1:0]         char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]        cell_index,
    input  logic [tcw_pkg::COLOR_W-1:0]        foreground_color,
    input  logic [tcw_pkg::COLOR_W-1:0]        background_color,
    output logic [tcw_pkg::CELL_W-1:0]         cell_data,
    output logic [tcw_pkg::COLOUT_W-1:0]       cursor_col,
    output logic [tcw_pkg::ROWOUT_W-1:0]       cursor_row,
    output logic [tcw_pkg::CURIDX_W-1:0]       cursor_index,
    output logic                               cursor_sent,
    output logic                               scrolled
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(COLUMNS + 1);
    localparam int RW       = $clog2(ROWS);
    localparam int IW       = $clog2(CELLS + 1);
    localparam int COPY_END = CELLS - COLUMNS;
    localparam int COL_OW   = tcw_pkg::COLOUT_W;
    localparam int ROW_OW   = tcw_pkg::ROWOUT_W;
    localparam int IDX_OW   = tcw_pkg::CURIDX_W;

    logic [tcw_pkg::CELL_W-1:0] cells_mem [CELLS];

    // latched item
    logic [tcw_pkg::CMD_W-1:0]   cmd_reg;
    logic [tcw_pkg::CODE_W-1:0]  code_reg;
    logic [tcw_pkg::INDEX_W-1:0] index_reg;

    // cursor: base_reg tracks row_reg * COLUMNS
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] base_reg, base_next;
    logic          sent_reg, sent_next;
    logic          scr_reg, scr_next;

    // sweep pipeline: read at cnt, write in the next cycle
    logic [AW-1:0]         cnt_reg, cnt_next;
    tcw_pkg::sweep_mode_t  mode_reg, mode_next;
    logic                  pend_valid_reg;
    logic [AW-1:0]         pend_addr_reg;
    logic                  pend_copy_reg;

    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    logic [tcw_pkg::CELL_W-1:0] color;
    logic [tcw_pkg::CELL_W-1:0] blank_cur;
    logic [AW-1:0]              cursor_addr;
    logic [AW-1:0]              src_addr;
    logic                       copy_row;
    logic                       in_range;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;

    assign color       = {background_color, foreground_color, tcw_pkg::CHAR_NONE};
    assign blank_cur   = {background_color, foreground_color, tcw_pkg::CHAR_BLANK};
    assign cursor_addr = base_reg + AW'(col_reg);
    assign src_addr    = cnt_reg + AW'(COLUMNS);
    assign copy_row    = 32'(cnt_reg) < COPY_END;
    assign in_range    = 32'(index_reg) < CELLS;

    assign stat.cmd        = cmd_reg;
    assign stat.is_zero    = code_reg == tcw_pkg::CHAR_NONE;
    assign stat.is_newline = code_reg == tcw_pkg::CHAR_NEWLINE;
    assign stat.is_erase   = code_reg == tcw_pkg::CHAR_ERASE;
    assign stat.col_zero   = col_reg == '0;
    assign stat.col_full   = 32'(col_reg) >= COLUMNS;
    assign stat.row_last   = 32'(row_reg) == ROWS - 1;
    assign stat.cnt_last   = 32'(cnt_reg) == CELLS - 1;
    assign stat.sweep_init = mode_reg == tcw_pkg::SW_INIT;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cursor_addr;
        mem_wdata = {background_color, foreground_color, code_reg};
        if (pend_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            case (mode_reg)
                tcw_pkg::SW_INIT:    mem_wdata = tcw_pkg::RESET_CELL;
                tcw_pkg::SW_CLEAR:   mem_wdata = blank_cur;
                tcw_pkg::SW_RECOLOR: mem_wdata = rdata_reg | color;
                default:             mem_wdata = pend_copy_reg ? rdata_reg : blank_cur;
            endcase
        end
        else if (ctrl.put_char)
        begin
            mem_we = 1'b1;
        end
        else if (ctrl.erase_char)
        begin
            mem_we    = 1'b1;
            mem_waddr = cursor_addr - AW'(1);
            mem_wdata = blank_cur;
        end
    end

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = cnt_reg;
        if (ctrl.sweep_run)
        begin
            if (mode_reg == tcw_pkg::SW_RECOLOR)
            begin
                mem_re = 1'b1;
            end
            else if (mode_reg == tcw_pkg::SW_SCROLL && copy_row)
            begin
                mem_re    = 1'b1;
                mem_raddr = src_addr;
            end
        end
        else if (ctrl.read_cell)
        begin
            mem_re    = in_range;
            mem_raddr = AW'(index_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= cells_mem[mem_raddr];
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        sent_next = sent_reg;
        scr_next  = scr_reg;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;

        if (ctrl.advance_row)
        begin
            col_next  = '0;
            row_next  = row_reg + RW'(1);
            base_next = base_reg + AW'(COLUMNS);
        end
        else if (ctrl.home_col)
        begin
            col_next = '0;
        end
        else if (ctrl.put_char)
        begin
            col_next = col_reg + CW'(1);
        end
        else if (ctrl.erase_char)
        begin
            col_next = col_reg - CW'(1);
        end

        if (ctrl.load_in)
        begin
            sent_next = 1'b0;
            scr_next  = 1'b0;
        end
        else
        begin
            if (ctrl.put_char || ctrl.erase_char || ctrl.mark_sent)
            begin
                sent_next = 1'b1;
            end
            if (ctrl.sweep_begin && ctrl.sweep_mode == tcw_pkg::SW_SCROLL)
            begin
                scr_next = 1'b1;
            end
        end

        if (ctrl.sweep_begin)
        begin
            cnt_next  = '0;
            mode_next = ctrl.sweep_mode;
        end
        else if (ctrl.sweep_run)
        begin
            cnt_next = cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            base_reg       <= '0;
            sent_reg       <= 1'b0;
            scr_reg        <= 1'b0;
            cnt_reg        <= '0;
            mode_reg       <= tcw_pkg::SW_INIT;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            base_reg       <= base_next;
            sent_reg       <= sent_next;
            scr_reg        <= scr_next;
            cnt_reg        <= cnt_next;
            mode_reg       <= mode_next;
            pend_valid_reg <= ctrl.sweep_run;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= cnt_reg;
        pend_copy_reg <= copy_row;
        if (ctrl.load_in)
        begin
            cmd_reg   <= command;
            code_reg  <= char_code;
            index_reg <= cell_index;
        end
        if (ctrl.load_out)
        begin
            cell_data    <= (cmd_reg == tcw_pkg::CMD_READ && in_range) ? rdata_reg : '0;
            cursor_col   <= COL_OW'(col_reg);
            cursor_row   <= ROW_OW'(row_reg);
            cursor_index <= IDX_OW'(IW'(base_reg) + IW'(col_reg));
            cursor_sent  <= sent_reg;
            scrolled     <= scr_reg;
        end
    end

endmodule

// ===== design/tcw_checker.sv =====
module tcw_checker
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tcw_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [tcw_pkg::ROWOUT_W-1:0] LAST_ROW = tcw_pkg::ROWOUT_W'(ROWS - 1);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back accept");

    // cursor column never past the wrap column
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[22:16]) <= COLUMNS)
        else $error("cursor column out of range");

    // a scroll only comes from a put and leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |-> m_tdata[39] && (m_tdata[27:23] == LAST_ROW))
        else $error("scroll without cursor update or off last row");

    // cursor updates come from puts, which return no cell data
    a_put_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[39] |-> m_tdata[15:0] == '0)
        else $error("cell data on a put result");

endmodule

bind text_console_writer_core tcw_checker
#(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
)
u_tcw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
